// ----- design/ejs_pkg.sv -----
// package for the event join status machine
// holds status and command codes, config register indexes and the item structs
// no dependencies
package ejs_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int ATTACH_W          = 5;

    typedef enum logic [1:0] {
        ST_WAITING  = 2'd0,
        ST_PENDING  = 2'd1,
        ST_HAPPENED = 2'd2,
        ST_DISPOSED = 2'd3
    } ejs_status_t;

    typedef enum logic [2:0] {
        FN_WAIT       = 3'd0,
        FN_HAPPEN     = 3'd1,
        FN_DISPOSE    = 3'd2,
        FN_UPDATE     = 3'd3,
        FN_MIN_REACH  = 3'd4,
        FN_ENDED      = 3'd5,
        FN_PROC_DISP  = 3'd6,
        FN_SET_STATUS = 3'd7
    } ejs_func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EVENT_DATE     = 3'd0,
        CFG_HAS_CONDITION  = 3'd1,
        CFG_HAS_CONTAINER  = 3'd2,
        CFG_MUTE           = 3'd3,
        CFG_ATTACHED_COUNT = 3'd4
    } ejs_cfg_index_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [1:0]  new_status;
        logic        container_running;
        logic [31:0] container_date;
    } ejs_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       error;
        logic       push_state;
        logic       condition_default;
        logic       status_changed;
        logic [1:0] previous_status;
    } ejs_out_t;

    typedef struct packed {
        logic [31:0]         event_date;
        logic                has_condition;
        logic                has_container;
        logic                mute;
        logic [ATTACH_W-1:0] attached_count;
    } ejs_cfg_t;

    typedef struct packed {
        logic [1:0] status;
        logic       wait_req;
        logic       happen_req;
        logic       dispose_req;
    } ejs_flags_t;

endpackage

// ----- design/ejs_step.sv -----
// next-state and result logic for one command of the event join status machine
// purely combinational; depends on ejs_pkg
module ejs_step
    import ejs_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int CNT_W         = $clog2(MAX_PROCESSES + 1)
)
(
    input  ejs_in_t           item,
    input  ejs_cfg_t          cfg,
    input  ejs_flags_t        flags,
    input  logic [CNT_W-1:0]  min_cnt,
    input  logic [CNT_W-1:0]  ended_cnt,
    input  logic [CNT_W-1:0]  disp_cnt,
    output ejs_flags_t        flags_next,
    output logic [CNT_W-1:0]  min_cnt_next,
    output logic [CNT_W-1:0]  ended_cnt_next,
    output logic [CNT_W-1:0]  disp_cnt_next,
    output ejs_out_t          result
);

    localparam int CMP_W = (CNT_W + 1 > ATTACH_W) ? CNT_W + 1 : ATTACH_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic             uf_wait;
    logic             uf_happen;
    logic             uf_dispose;
    logic             upd_apply;
    logic [1:0]       upd_status;
    logic             upd_push;
    logic             upd_default;
    logic [CMP_W-1:0] att_x;
    logic [CMP_W-1:0] min_x;
    logic [CMP_W-1:0] disp_x;
    logic [CMP_W-1:0] done_x;
    logic             is_waiting;
    logic             is_pending;

    assign uf_wait    = flags.wait_req    | (item.func == FN_WAIT);
    assign uf_happen  = flags.happen_req  | (item.func == FN_HAPPEN);
    assign uf_dispose = flags.dispose_req | (item.func == FN_DISPOSE);

    assign att_x  = CMP_W'(cfg.attached_count);
    assign min_x  = CMP_W'(min_cnt);
    assign disp_x = CMP_W'(disp_cnt);
    assign done_x = CMP_W'(ended_cnt) + CMP_W'(disp_cnt);

    assign is_waiting = (flags.status == ST_WAITING);
    assign is_pending = (flags.status == ST_PENDING);

    // status update rule
    always_comb
    begin
        upd_apply   = 1'b0;
        upd_status  = ST_WAITING;
        upd_push    = 1'b0;
        upd_default = 1'b0;
        if (uf_wait)
        begin
            upd_apply  = 1'b1;
            upd_status = ST_WAITING;
        end
        else if (uf_happen)
        begin
            upd_apply  = 1'b1;
            upd_push   = 1'b1;
            upd_status = ST_HAPPENED;
        end
        else if (uf_dispose)
        begin
            upd_apply  = 1'b1;
            upd_status = ST_DISPOSED;
        end
        else if (cfg.attached_count != '0)
        begin
            if (cfg.has_condition && is_waiting && min_x == att_x)
            begin
                upd_apply  = 1'b1;
                upd_status = ST_PENDING;
            end
            else if (done_x == att_x && cfg.has_condition && is_pending)
            begin
                upd_default = 1'b1;
            end
            else if (done_x == att_x && !cfg.has_condition && is_waiting)
            begin
                upd_apply  = 1'b1;
                upd_push   = 1'b1;
                upd_status = ST_HAPPENED;
            end
            else if (is_waiting && disp_x == att_x)
            begin
                upd_apply  = 1'b1;
                upd_status = ST_DISPOSED;
            end
        end
        else if (is_waiting)
        begin
            if (cfg.has_condition)
            begin
                upd_apply  = 1'b1;
                upd_status = ST_PENDING;
            end
            else if (cfg.has_container && cfg.event_date <= item.container_date)
            begin
                upd_apply  = 1'b1;
                upd_push   = 1'b1;
                upd_status = ST_HAPPENED;
            end
        end
    end

    // command dispatch
    always_comb
    begin
        logic run_update;
        run_update     = 1'b0;
        flags_next     = flags;
        min_cnt_next   = min_cnt;
        ended_cnt_next = ended_cnt;
        disp_cnt_next  = disp_cnt;
        result                   = '0;
        result.previous_status   = flags.status;

        unique case (item.func)
            FN_WAIT:
            begin
                if (!is_waiting)
                begin
                    if (flags.wait_req)
                        result.error = 1'b1;
                    else if (cfg.has_container)
                        flags_next.wait_req = 1'b1;
                    else
                        run_update = 1'b1;
                end
            end
            FN_HAPPEN:
            begin
                if (!is_waiting && !is_pending)
                    result.error = 1'b1;
                else if (flags.happen_req)
                    result.error = 1'b1;
                else if (cfg.has_container)
                    flags_next.happen_req = 1'b1;
                else
                    run_update = 1'b1;
            end
            FN_DISPOSE:
            begin
                if (flags.status == ST_HAPPENED || flags.status == ST_DISPOSED)
                    result.error = 1'b1;
                else if (flags.dispose_req)
                    result.error = 1'b1;
                else if (cfg.has_container)
                    flags_next.dispose_req = 1'b1;
                else
                    run_update = 1'b1;
            end
            FN_UPDATE:
                run_update = 1'b1;
            FN_MIN_REACH:
                min_cnt_next = (min_cnt >= CNT_MAX) ? CNT_MAX : min_cnt + CNT_ONE;
            FN_ENDED:
                ended_cnt_next = (ended_cnt >= CNT_MAX) ? CNT_MAX : ended_cnt + CNT_ONE;
            FN_PROC_DISP:
                disp_cnt_next = (disp_cnt >= CNT_MAX) ? CNT_MAX : disp_cnt + CNT_ONE;
            FN_SET_STATUS:
            begin
                if (cfg.has_container && item.container_running)
                    result.error = 1'b1;
                else
                begin
                    flags_next     = '0;
                    flags_next.status = item.new_status;
                    min_cnt_next   = '0;
                    ended_cnt_next = '0;
                    disp_cnt_next  = '0;
                end
            end
            default:
            begin
                result.error = 1'b1;
            end
        endcase

        if (run_update)
        begin
            // any set request is always consumed by the update
            flags_next.wait_req    = 1'b0;
            flags_next.happen_req  = 1'b0;
            flags_next.dispose_req = 1'b0;
            if (upd_apply)
            begin
                flags_next.status     = upd_status;
                result.push_state     = upd_push & ~cfg.mute;
                result.error          = (flags.status == upd_status);
                result.status_changed = (flags.status != upd_status);
                if (upd_status != ST_PENDING)
                begin
                    min_cnt_next   = '0;
                    ended_cnt_next = '0;
                    disp_cnt_next  = '0;
                end
            end
            else if (upd_default)
                result.condition_default = 1'b1;
            else
                result.error = 1'b1;
        end

        result.status = flags_next.status;
    end

endmodule

// ----- design/ejs_cfg_regs.sv -----
// configuration registers of the event join status machine
// plain write port, no read-back; depends on ejs_pkg
module ejs_cfg_regs
    import ejs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output ejs_cfg_t               cfg
);

    ejs_cfg_t cfg_reg;
    ejs_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EVENT_DATE:     cfg_next.event_date     = cfg_wdata;
                CFG_HAS_CONDITION:  cfg_next.has_condition  = cfg_wdata[0];
                CFG_HAS_CONTAINER:  cfg_next.has_container  = cfg_wdata[0];
                CFG_MUTE:           cfg_next.mute           = cfg_wdata[0];
                CFG_ATTACHED_COUNT: cfg_next.attached_count = cfg_wdata[ATTACH_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/event_join_status_fsm_core.sv -----
// top level of the event join status machine: input register, state, result register
// depends on ejs_pkg, ejs_cfg_regs and ejs_step
// accepted item: input register, then result register, which drives out_valid
// throughput: one item per cycle while the output is not stalled
// reset: status waiting, request flags, counters, config and both valid bits cleared
module event_join_status_fsm_core
    import ejs_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  ejs_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ejs_out_t               out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    ejs_cfg_t         cfg;
    logic             in_valid_reg;
    ejs_in_t          in_item_reg;
    logic             out_valid_reg;
    ejs_out_t         out_data_reg;
    ejs_flags_t       flags_reg;
    ejs_flags_t       flags_next;
    logic [CNT_W-1:0] min_cnt_reg;
    logic [CNT_W-1:0] min_cnt_next;
    logic [CNT_W-1:0] ended_cnt_reg;
    logic [CNT_W-1:0] ended_cnt_next;
    logic [CNT_W-1:0] disp_cnt_reg;
    logic [CNT_W-1:0] disp_cnt_next;
    ejs_out_t         result;
    logic             advance;
    logic             in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    ejs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ejs_step #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .CNT_W         (CNT_W)
    ) u_step (
        .item           (in_item_reg),
        .cfg            (cfg),
        .flags          (flags_reg),
        .min_cnt        (min_cnt_reg),
        .ended_cnt      (ended_cnt_reg),
        .disp_cnt       (disp_cnt_reg),
        .flags_next     (flags_next),
        .min_cnt_next   (min_cnt_next),
        .ended_cnt_next (ended_cnt_next),
        .disp_cnt_next  (disp_cnt_next),
        .result         (result)
    );

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '{status: ST_WAITING, default: 1'b0};
            min_cnt_reg   <= '0;
            ended_cnt_reg <= '0;
            disp_cnt_reg  <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                flags_reg     <= flags_next;
                min_cnt_reg   <= min_cnt_next;
                ended_cnt_reg <= ended_cnt_next;
                disp_cnt_reg  <= disp_cnt_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- design/ejs_checker.sv -----
// port-level checks on the result channel of the event join status machine
// depends on ejs_pkg; bound to event_join_status_fsm_core
module ejs_checker
    import ejs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_stall,
    input ejs_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result item changed while stalled");

    a_changed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status_changed |->
            !out_data.error && out_data.status != out_data.previous_status)
        else $error("status change flagged without a new status");

    a_default: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.condition_default |->
            !out_data.error && !out_data.status_changed &&
            out_data.status == ST_PENDING && out_data.previous_status == ST_PENDING)
        else $error("condition default outside pending");

    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.push_state |-> out_data.status == ST_HAPPENED)
        else $error("state push without happened status");

endmodule

bind event_join_status_fsm_core ejs_checker u_chk (.*);

// ----- verif/event_join_status_fsm_core_tb.sv -----
// self-checking testbench for event_join_status_fsm_core: directed command table, then
// random commands and join sequences under changing register settings and random stalls
// depends on ejs_pkg and the event_join_status_fsm_core design
module event_join_status_fsm_core_tb;
    import ejs_pkg::*;

    typedef struct packed {
        bit             is_reg;
        ejs_cfg_index_t reg_idx;
        logic [31:0]    reg_val;
        ejs_in_t        cmd;
        bit             typed;
        ejs_out_t       want;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    ejs_in_t                in_data = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    ejs_out_t               out_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // predicted block state and register copy
    ejs_status_t p_status = ST_WAITING;
    bit          p_wait_rq = 1'b0;
    bit          p_happen_rq = 1'b0;
    bit          p_dispose_rq = 1'b0;
    int          p_min = 0;
    int          p_ended = 0;
    int          p_disp = 0;
    logic [31:0] c_event_date = '0;
    bit          c_cond = 1'b0;
    bit          c_cont = 1'b0;
    bit          c_mute = 1'b0;
    int          c_attached = 0;
    bit          r_err;
    bit          r_push;
    bit          r_dflt;
    bit          r_chg;

    ejs_out_t    status_due_q[$];
    int          fail_cnt = 0;
    int          item_cnt = 0;
    int          tx_idle_pct = 38;
    int          rx_idle_pct = 70;
    int          hold_seq = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    event_join_status_fsm_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function void take_status(ejs_status_t s);
        ejs_status_t last;
        last = p_status;
        p_status = s;
        p_wait_rq = 1'b0;
        p_happen_rq = 1'b0;
        p_dispose_rq = 1'b0;
        if (s != ST_PENDING)
        begin
            p_min = 0;
            p_ended = 0;
            p_disp = 0;
        end
        if (last == s)
            r_err = 1'b1;
        else
        begin
            r_err = 1'b0;
            r_chg = 1'b1;
        end
    endfunction

    function void run_update(logic [31:0] cdate);
        if (p_wait_rq)
            take_status(ST_WAITING);
        else if (p_happen_rq)
        begin
            r_push = !c_mute;
            take_status(ST_HAPPENED);
        end
        else if (p_dispose_rq)
            take_status(ST_DISPOSED);
        else if (c_attached != 0)
        begin
            if (c_cond && p_status == ST_WAITING && p_min == c_attached)
                take_status(ST_PENDING);
            else if (p_ended + p_disp == c_attached && c_cond && p_status == ST_PENDING)
            begin
                r_dflt = 1'b1;
                r_err = 1'b0;
            end
            else if (p_ended + p_disp == c_attached && !c_cond && p_status == ST_WAITING)
            begin
                r_push = !c_mute;
                take_status(ST_HAPPENED);
            end
            else if (p_status == ST_WAITING && p_disp == c_attached)
                take_status(ST_DISPOSED);
            else
                r_err = 1'b1;
        end
        else if (p_status == ST_WAITING && c_cond)
            take_status(ST_PENDING);
        else if (p_status == ST_WAITING && c_cont && c_event_date <= cdate)
        begin
            r_push = !c_mute;
            take_status(ST_HAPPENED);
        end
        else
            r_err = 1'b1;
    endfunction

    function int bump(int v);
        return (v >= MAX_PROCESSES_DEF) ? MAX_PROCESSES_DEF : v + 1;
    endfunction

    // expected result of one command, advancing the predicted state
    function ejs_out_t next_event_status(ejs_in_t c);
        ejs_out_t    o;
        ejs_status_t prev;
        prev = p_status;
        r_err = 1'b0;
        r_push = 1'b0;
        r_dflt = 1'b0;
        r_chg = 1'b0;
        case (ejs_func_t'(c.func))
            FN_WAIT:
            begin
                if (p_status != ST_WAITING)
                begin
                    if (p_wait_rq)
                        r_err = 1'b1;
                    else
                    begin
                        p_wait_rq = 1'b1;
                        if (!c_cont)
                            run_update(c.container_date);
                    end
                end
            end
            FN_HAPPEN:
            begin
                if (p_status == ST_HAPPENED || p_status == ST_DISPOSED || p_happen_rq)
                    r_err = 1'b1;
                else
                begin
                    p_happen_rq = 1'b1;
                    if (!c_cont)
                        run_update(c.container_date);
                end
            end
            FN_DISPOSE:
            begin
                if (p_status == ST_HAPPENED || p_status == ST_DISPOSED || p_dispose_rq)
                    r_err = 1'b1;
                else
                begin
                    p_dispose_rq = 1'b1;
                    if (!c_cont)
                        run_update(c.container_date);
                end
            end
            FN_UPDATE:
                run_update(c.container_date);
            FN_MIN_REACH:
                p_min = bump(p_min);
            FN_ENDED:
                p_ended = bump(p_ended);
            FN_PROC_DISP:
                p_disp = bump(p_disp);
            default:
            begin
                if (c_cont && c.container_running)
                    r_err = 1'b1;
                else
                begin
                    p_status = ejs_status_t'(c.new_status);
                    p_wait_rq = 1'b0;
                    p_happen_rq = 1'b0;
                    p_dispose_rq = 1'b0;
                    p_min = 0;
                    p_ended = 0;
                    p_disp = 0;
                end
            end
        endcase
        o.status = p_status;
        o.error = r_err;
        o.push_state = r_push;
        o.condition_default = r_dflt;
        o.status_changed = r_chg;
        o.previous_status = prev;
        return o;
    endfunction

    function plan_row_t reg_row(ejs_cfg_index_t idx, logic [31:0] v);
        plan_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = v;
        return r;
    endfunction

    function plan_row_t cmd_row(ejs_func_t f, ejs_status_t ns, bit run, logic [31:0] d);
        plan_row_t r;
        r = '0;
        r.cmd.func = f;
        r.cmd.new_status = ns;
        r.cmd.container_running = run;
        r.cmd.container_date = d;
        return r;
    endfunction

    function plan_row_t known_row(ejs_func_t f, ejs_status_t ns, bit run, logic [31:0] d,
                                  ejs_status_t st, bit er, bit pu, bit ch, ejs_status_t pv);
        plan_row_t r;
        r = cmd_row(f, ns, run, d);
        r.typed = 1'b1;
        r.want.status = st;
        r.want.error = er;
        r.want.push_state = pu;
        r.want.condition_default = 1'b0;
        r.want.status_changed = ch;
        r.want.previous_status = pv;
        return r;
    endfunction

    function logic [31:0] pick_date();
        case ($urandom_range(3))
            0: return c_event_date + $urandom_range(2) - 1;
            1: return $urandom;
            2: return 32'h0;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function ejs_in_t rand_cmd();
        ejs_in_t d;
        int      w;
        w = $urandom_range(99);
        if (w < 8)
            d.func = FN_WAIT;
        else if (w < 18)
            d.func = FN_HAPPEN;
        else if (w < 26)
            d.func = FN_DISPOSE;
        else if (w < 50)
            d.func = FN_UPDATE;
        else if (w < 62)
            d.func = FN_MIN_REACH;
        else if (w < 72)
            d.func = FN_ENDED;
        else if (w < 82)
            d.func = FN_PROC_DISP;
        else
            d.func = FN_SET_STATUS;
        d.new_status = 2'($urandom_range(3));
        d.container_running = 1'($urandom_range(1));
        d.container_date = pick_date();
        return d;
    endfunction

    function ejs_in_t cmd_of(ejs_func_t f);
        ejs_in_t d;
        d = rand_cmd();
        d.func = f;
        return d;
    endfunction

    task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want)
        begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic offer(ejs_in_t d, bit typed, ejs_out_t want);
        ejs_out_t got;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = next_event_status(d);
        status_due_q.push_back(typed ? want : got);
        item_cnt++;
    endtask

    task automatic offer_rand(ejs_in_t d);
        offer(d, 1'b0, '0);
    endtask

    // wait until every result is back and the pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (status_due_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(ejs_cfg_index_t idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        case (idx)
            CFG_EVENT_DATE:    c_event_date = v;
            CFG_HAS_CONDITION: c_cond = v[0];
            CFG_HAS_CONTAINER: c_cont = v[0];
            CFG_MUTE:          c_mute = v[0];
            default:           c_attached = int'(v[ATTACH_W-1:0]);
        endcase
    endtask

    task automatic pick_setting();
        logic [31:0] v;
        int          r;
        drain();
        case ($urandom_range(2))
            0: write_reg(CFG_EVENT_DATE, 32'h0);
            1: write_reg(CFG_EVENT_DATE, 32'hffff_ffff);
            default: write_reg(CFG_EVENT_DATE, $urandom);
        endcase
        v = $urandom;
        write_reg(CFG_HAS_CONDITION, v);
        v = $urandom;
        write_reg(CFG_HAS_CONTAINER, v);
        v = $urandom;
        write_reg(CFG_MUTE, v);
        r = $urandom_range(19);
        v = $urandom;
        if (r < 8)
            v[4:0] = 5'($urandom_range(3));
        else if (r < 14)
            v[4:0] = 5'($urandom_range(8, 4));
        else if (r < 17)
            v[4:0] = 5'(MAX_PROCESSES_DEF);
        else if (r == 17)
            v[4:0] = 5'd0;
        else if (r == 18)
            v[4:0] = 5'd31;
        else
            v[4:0] = 5'(MAX_PROCESSES_DEF + 1);
        write_reg(CFG_ATTACHED_COUNT, v);
        cfg_we <= 1'b0;
    endtask

    // restart the event, report the attached processes and run it to its end
    task automatic join_round();
        ejs_in_t d;
        int      n;
        int      mode;
        d = cmd_of(FN_SET_STATUS);
        d.new_status = ST_WAITING;
        d.container_running = 1'b0;
        offer_rand(d);
        n = c_attached;
        if (c_cond)
        begin
            repeat (n) offer_rand(cmd_of(FN_MIN_REACH));
            offer_rand(cmd_of(FN_UPDATE));
        end
        mode = $urandom_range(2);
        repeat (n)
        begin
            if (mode == 0 || (mode == 2 && $urandom_range(1) == 0))
                offer_rand(cmd_of(FN_ENDED));
            else
                offer_rand(cmd_of(FN_PROC_DISP));
        end
        offer_rand(cmd_of(FN_UPDATE));
        if ($urandom_range(1))
            offer_rand(rand_cmd());
        offer_rand(cmd_of(FN_UPDATE));
    endtask

    // receiver stalls, with a long hold-off whenever one is requested
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= 80;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        ejs_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_due_q.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: result with nothing expected, actual %h", $time, out_data);
            end
            else
            begin
                want = status_due_q.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("error", want.error, out_data.error);
                check_field("push_state", want.push_state, out_data.push_state);
                check_field("condition_default", want.condition_default,
                            out_data.condition_default);
                check_field("status_changed", want.status_changed, out_data.status_changed);
                check_field("previous_status", want.previous_status,
                            out_data.previous_status);
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        plan_row_t plan[$];
        plan_row_t row;
        bit        reg_open;
        int        target;

        // reset settings: no condition, no container, no processes, not muted
        plan.push_back(known_row(FN_UPDATE, ST_WAITING, 1'b0, 32'h0,
                                 ST_WAITING, 1'b1, 1'b0, 1'b0, ST_WAITING));
        plan.push_back(known_row(FN_WAIT, ST_WAITING, 1'b0, 32'h0,
                                 ST_WAITING, 1'b0, 1'b0, 1'b0, ST_WAITING));
        plan.push_back(known_row(FN_HAPPEN, ST_WAITING, 1'b0, 32'hffff_ffff,
                                 ST_HAPPENED, 1'b0, 1'b1, 1'b1, ST_WAITING));
        plan.push_back(known_row(FN_HAPPEN, ST_WAITING, 1'b1, 32'h0,
                                 ST_HAPPENED, 1'b1, 1'b0, 1'b0, ST_HAPPENED));
        plan.push_back(known_row(FN_DISPOSE, ST_DISPOSED, 1'b0, 32'h0,
                                 ST_HAPPENED, 1'b1, 1'b0, 1'b0, ST_HAPPENED));
        plan.push_back(known_row(FN_WAIT, ST_PENDING, 1'b1, 32'hffff_ffff,
                                 ST_WAITING, 1'b0, 1'b0, 1'b1, ST_HAPPENED));
        plan.push_back(known_row(FN_MIN_REACH, ST_HAPPENED, 1'b1, 32'h0,
                                 ST_WAITING, 1'b0, 1'b0, 1'b0, ST_WAITING));
        plan.push_back(cmd_row(FN_ENDED, ST_DISPOSED, 1'b0, 32'hffff_ffff));
        plan.push_back(cmd_row(FN_PROC_DISP, ST_PENDING, 1'b1, 32'h0));
        plan.push_back(known_row(FN_SET_STATUS, ST_DISPOSED, 1'b1, 32'h0,
                                 ST_DISPOSED, 1'b0, 1'b0, 1'b0, ST_WAITING));
        plan.push_back(cmd_row(FN_SET_STATUS, ST_WAITING, 1'b0, 32'h0));
        plan.push_back(cmd_row(FN_DISPOSE, ST_WAITING, 1'b0, 32'h1234_5678));
        // container present, date at its top, muted
        plan.push_back(reg_row(CFG_HAS_CONTAINER, 32'h1));
        plan.push_back(reg_row(CFG_EVENT_DATE, 32'hffff_ffff));
        plan.push_back(reg_row(CFG_MUTE, 32'h1));
        plan.push_back(cmd_row(FN_SET_STATUS, ST_WAITING, 1'b0, 32'h0));
        plan.push_back(known_row(FN_SET_STATUS, ST_HAPPENED, 1'b1, 32'h0,
                                 ST_WAITING, 1'b1, 1'b0, 1'b0, ST_WAITING));
        plan.push_back(cmd_row(FN_UPDATE, ST_WAITING, 1'b0, 32'hffff_fffe));
        plan.push_back(cmd_row(FN_UPDATE, ST_WAITING, 1'b0, 32'hffff_ffff));
        // conditioned event with one process
        plan.push_back(reg_row(CFG_HAS_CONDITION, 32'h1));
        plan.push_back(reg_row(CFG_ATTACHED_COUNT, 32'h1));
        plan.push_back(reg_row(CFG_EVENT_DATE, 32'h0));
        plan.push_back(cmd_row(FN_SET_STATUS, ST_WAITING, 1'b0, 32'h0));
        plan.push_back(cmd_row(FN_MIN_REACH, ST_WAITING, 1'b0, 32'h0));
        plan.push_back(cmd_row(FN_UPDATE, ST_WAITING, 1'b0, 32'h0));
        plan.push_back(cmd_row(FN_ENDED, ST_WAITING, 1'b0, 32'h0));
        plan.push_back(cmd_row(FN_UPDATE, ST_WAITING, 1'b1, 32'h0));
        plan.push_back(cmd_row(FN_HAPPEN, ST_WAITING, 1'b0, 32'h0));
        plan.push_back(cmd_row(FN_HAPPEN, ST_WAITING, 1'b1, 32'hffff_ffff));
        plan.push_back(cmd_row(FN_UPDATE, ST_WAITING, 1'b0, 32'h0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        reg_open = 1'b0;
        for (int k = 0; k < plan.size(); k++)
        begin
            row = plan[k];
            if (row.is_reg)
            begin
                if (!reg_open)
                    drain();
                reg_open = 1'b1;
                write_reg(row.reg_idx, row.reg_val);
            end
            else
            begin
                if (reg_open)
                    cfg_we <= 1'b0;
                reg_open = 1'b0;
                offer(row.cmd, row.typed, row.want);
            end
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 70 : 0;
            rx_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 38 : 0;
            target = item_cnt + 450;
            pick_setting();
            hold_seq <= hold_seq + 1;
            repeat (30) offer_rand(rand_cmd());
            while (item_cnt < target)
            begin
                pick_setting();
                if ($urandom_range(1))
                begin
                    join_round();
                    join_round();
                end
                else
                    repeat (40) offer_rand(rand_cmd());
            end
        end

        in_valid <= 1'b0;
        while (status_due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ejs_pkg.sv
design/ejs_step.sv
design/ejs_cfg_regs.sv
design/event_join_status_fsm_core.sv
design/ejs_checker.sv
verif/event_join_status_fsm_core_tb.sv
